@@ design/multichannel_pwm_step_scheduler_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel PWM step scheduler
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_PWM_STEP_SCHEDULER_MACROS_SVH
`define MULTICHANNEL_PWM_STEP_SCHEDULER_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define MPSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle property failed");

// The consequent must hold in the same cycle as the antecedent.
`define MPSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle property failed");

`endif

@@ design/mpss_pkg.sv @@
// ----------------------------------------------------------------------------
// mpss_pkg
// Constants, types and codes shared by the PWM step scheduler modules.
// ----------------------------------------------------------------------------
package mpss_pkg;

   // Number of channels held in the duty stores.
   localparam int CHANNELS = 32;
   // Four result bytes carry at most 32 channels.
   localparam int MAX_RESULTS = 4;
   localparam int BYTE_W = 8;
   localparam int CAP = (CHANNELS < MAX_RESULTS * BYTE_W) ? CHANNELS : MAX_RESULTS * BYTE_W;
   // Store index width and channel count width.
   localparam int CHAN_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int COUNT_W = 6;
   localparam int DUTY_W = 8;
   localparam int CHAN_IN_W = 5;

   localparam logic [DUTY_W-1:0] LEVEL_MAX = 8'd255;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

   // Item kinds carried on tuser.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_STEP = 1'b1;

   // Register index select, taken from paddr[2].
   localparam logic REG_ACTIVE_CHANNELS = 1'b0;

   // Control for the duty stores.
   typedef struct packed {
      logic              wr_en;
      logic [CHAN_W-1:0] wr_index;
      logic [DUTY_W-1:0] wr_data;
      logic              copy;
   } store_ctrl_type;

   // Result of one channel compare.
   typedef struct packed {
      logic on;
      logic take;
   } cmp_result_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

endpackage

@@ design/mpss_duty_store.sv @@
// ----------------------------------------------------------------------------
// mpss_duty_store
// Pending and active duty stores with a single scan read port. Writes land in
// the pending store; a copy moves all pending duties to the active store.
// ----------------------------------------------------------------------------
module mpss_duty_store (
   input  logic                              clock,
   input  logic                              reset,
   input  mpss_pkg::store_ctrl_type          ctrl,
   input  logic [mpss_pkg::CHAN_W-1:0]       rd_index,
   output logic [mpss_pkg::DUTY_W-1:0]       rd_data
);

   logic [mpss_pkg::DUTY_W-1:0] pending_ff [mpss_pkg::CHANNELS];
   logic [mpss_pkg::DUTY_W-1:0] active_ff [mpss_pkg::CHANNELS];

   // Pending store takes duty writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mpss_pkg::CHANNELS; i++) begin
            pending_ff[i] <= '0;
         end
      end else if (ctrl.wr_en) begin
         pending_ff[ctrl.wr_index] <= ctrl.wr_data;
      end
   end

   // Active store is refreshed as a whole at a cycle start.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mpss_pkg::CHANNELS; i++) begin
            active_ff[i] <= '0;
         end
      end else if (ctrl.copy) begin
         for (int i = 0; i < mpss_pkg::CHANNELS; i++) begin
            active_ff[i] <= pending_ff[i];
         end
      end
   end

   assign rd_data = active_ff[rd_index];

endmodule

@@ design/mpss_cmp_unit.sv @@
// ----------------------------------------------------------------------------
// mpss_cmp_unit
// Shared compare unit: decides one channel's on bit and whether its duty is
// the new least duty above the current level.
// ----------------------------------------------------------------------------
module mpss_cmp_unit (
   input  logic [mpss_pkg::DUTY_W-1:0] duty,
   input  logic [mpss_pkg::DUTY_W-1:0] level,
   input  logic [mpss_pkg::DUTY_W-1:0] least,
   output mpss_pkg::cmp_result_type    result
);

   logic above;

   // A channel is on above the level; every channel is on at the top level.
   always_comb begin
      above = duty > level;
      result.on = above || (level == mpss_pkg::LEVEL_MAX);
      result.take = above && (duty < least);
   end

endmodule

@@ design/multichannel_pwm_step_scheduler.sv @@
// ----------------------------------------------------------------------------
// multichannel_pwm_step_scheduler
// Event-driven PWM step scheduler: stores channel duties and, on each step,
// sends the channel on-mask as bytes together with the next change level.
// ----------------------------------------------------------------------------
// A duty write is taken in idle, and the block stays ready in the next cycle.
// A step scans the n active channels in order: one channel per cycle, unless a
// byte stalls the scan, passes through the shared compare unit.
// A byte stalls the scan only while the previous result still waits.
// Reset is synchronous and active high; it clears both duty stores, the
// level and the dirty flag, and sets the channel count to 32.
// ----------------------------------------------------------------------------
module multichannel_pwm_step_scheduler (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // channel[4:0], duty[12:5], zero[15:13]
   input  logic        req_tuser,   // mode[0]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // pattern_byte[7:0], next_level[15:8]
   output logic        rsp_tlast,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW = mpss_pkg::COUNT_W;
   localparam int DW = mpss_pkg::DUTY_W;

   mpss_pkg::state_type       state_ff, state_in;
   logic [CW-1:0]             active_channels_ff;
   logic [CW-1:0]             eff_count;
   logic                      dirty_ff, dirty_in;
   logic [DW-1:0]             level_ff, level_in;
   logic [CW-1:0]             ch_ff, ch_in;
   logic [7:0]                bits_ff, bits_in;
   logic [DW-1:0]             least_ff, least_in;
   logic                      out_valid_ff, out_valid_in;
   logic [15:0]               out_data_ff, out_data_in;
   logic                      out_last_ff, out_last_in;

   logic                      req_fire;
   logic                      req_mode;
   logic [mpss_pkg::CHAN_IN_W-1:0] req_channel;
   logic [DW-1:0]             req_duty;
   logic                      chan_ok;
   logic                      byte_end;
   logic                      step_end;
   logic                      stall;
   logic                      advance;
   logic [CW-1:0]             ch_next;
   logic [7:0]                pattern;
   logic [DW-1:0]             least_new;
   logic [DW-1:0]             next_level;
   logic [DW-1:0]             rd_duty;
   mpss_pkg::store_ctrl_type  store_ctrl;
   mpss_pkg::cmp_result_type  cmp;
   logic                      csr_wr;

   // Configuration register write and read.
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_channels_ff <= mpss_pkg::COUNT_RESET;
      end else if (csr_wr && (csr_paddr[2] == mpss_pkg::REG_ACTIVE_CHANNELS)) begin
         active_channels_ff <= csr_pwdata[CW-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == mpss_pkg::REG_ACTIVE_CHANNELS) ?
                       {{(32-CW){1'b0}}, active_channels_ff} : 32'd0;

   // Effective channel count: zero counts as one, large values saturate.
   always_comb begin
      if (active_channels_ff == '0) begin
         eff_count = CW'(1);
      end else if (active_channels_ff > CW'(mpss_pkg::CAP)) begin
         eff_count = CW'(mpss_pkg::CAP);
      end else begin
         eff_count = active_channels_ff;
      end
   end

   // Input item fields.
   assign req_tready = (state_ff == mpss_pkg::ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign req_mode = req_tuser;
   assign req_channel = req_tdata[4:0];
   assign req_duty = req_tdata[12:5];
   assign chan_ok = {1'b0, req_channel} < eff_count;

   // Duty store control.
   always_comb begin
      store_ctrl.wr_en = req_fire && (req_mode == mpss_pkg::MODE_WRITE) && chan_ok;
      store_ctrl.wr_index = mpss_pkg::CHAN_W'(req_channel);
      store_ctrl.wr_data = req_duty;
      store_ctrl.copy = req_fire && (req_mode == mpss_pkg::MODE_STEP) &&
                        (level_ff == '0) && dirty_ff;
   end

   mpss_duty_store u_store (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (store_ctrl),
      .rd_index (ch_ff[mpss_pkg::CHAN_W-1:0]),
      .rd_data  (rd_duty)
   );

   mpss_cmp_unit u_cmp (
      .duty   (rd_duty),
      .level  (level_ff),
      .least  (least_ff),
      .result (cmp)
   );

   // Scan position and byte boundaries.
   assign ch_next = ch_ff + CW'(1);
   assign step_end = (ch_next == eff_count);
   assign byte_end = (ch_ff[2:0] == 3'd7) || step_end;
   assign stall = byte_end && out_valid_ff && !rsp_tready;
   assign advance = (state_ff == mpss_pkg::ST_SCAN) && !stall;
   assign pattern = {cmp.on, bits_ff[7:1]};
   assign least_new = cmp.take ? rd_duty : least_ff;
   assign next_level = (least_new == mpss_pkg::LEVEL_MAX) ? '0 : least_new;

   // Sequencer: duty writes in idle, one channel per cycle while scanning unless a byte stalls.
   always_comb begin
      state_in = state_ff;
      dirty_in = dirty_ff;
      level_in = level_ff;
      ch_in = ch_ff;
      bits_in = bits_ff;
      least_in = least_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      unique case (state_ff)
         mpss_pkg::ST_IDLE: begin
            if (store_ctrl.wr_en) begin
               dirty_in = 1'b1;
            end
            if (store_ctrl.copy) begin
               dirty_in = 1'b0;
            end
            if (req_fire && (req_mode == mpss_pkg::MODE_STEP)) begin
               ch_in = '0;
               bits_in = '0;
               least_in = mpss_pkg::LEVEL_MAX;
               state_in = mpss_pkg::ST_SCAN;
            end
         end
         mpss_pkg::ST_SCAN: begin
            if (advance) begin
               ch_in = ch_next;
               bits_in = byte_end ? 8'd0 : pattern;
               least_in = least_new;
               if (byte_end) begin
                  out_valid_in = 1'b1;
                  out_data_in = {(step_end ? next_level : 8'd0), pattern};
                  out_last_in = step_end;
               end
               if (step_end) begin
                  level_in = next_level;
                  state_in = mpss_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = mpss_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpss_pkg::ST_IDLE;
         dirty_ff <= 1'b0;
         level_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
         level_ff <= level_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Scan and output payload registers.
   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
      bits_ff <= bits_in;
      least_ff <= least_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tlast = out_last_ff;

endmodule

@@ design/mpss_checker.sv @@
// ----------------------------------------------------------------------------
// mpss_checker
// Port-level checks for the PWM step scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "multichannel_pwm_step_scheduler_macros.svh"

module mpss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result stays offered.
   `MPSS_ASSERT_NEXT(rsp_valid_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // A stalled result keeps its payload.
   `MPSS_ASSERT_NEXT(rsp_data_holds, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast))

   // A step transfer starts a scan, so no item is taken in the next cycle.
   `MPSS_ASSERT_NEXT(step_busy, clock, reset, req_tvalid && req_tready && req_tuser, !req_tready)

   // Only the final byte of a step carries a next level.
   `MPSS_ASSERT_SAME(level_on_last, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[15:8] == 8'd0)

endmodule

bind multichannel_pwm_step_scheduler mpss_checker u_mpss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

@@ test/multichannel_pwm_step_scheduler_tb.sv @@
// ----------------------------------------------------------------------------
// multichannel_pwm_step_scheduler_tb
// Self-checking bench for the PWM step scheduler. A short directed table is
// followed by random duty writes and PWM steps under several channel counts.
// A local model of the duty stores and the level predicts the mask bytes of all but typed rows.
// Both stream sides idle at random, and the result side also holds off for
// a long stretch.
// ----------------------------------------------------------------------------
module multichannel_pwm_step_scheduler_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ADDR_ACTIVE_CHANNELS = {mpss_pkg::REG_ACTIVE_CHANNELS, 2'b00};
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS = 48;
   localparam int NUM_PHASES = 7;
   localparam int NUM_ROWS = 24;

   // One expected mask byte.
   typedef struct {
      logic [7:0] pattern;
      logic [7:0] next_level;
      logic       last;
   } mask_byte_type;

   // One directed row; typed rows carry the pattern and next level of a step.
   typedef struct packed {
      logic       mode;
      logic [4:0] chan;
      logic [7:0] duty;
      logic       typed;
      logic [7:0] exp_pattern;
      logic [7:0] exp_next;
   } step_row_type;

   localparam step_row_type ROWS [NUM_ROWS] = '{
      '{mpss_pkg::MODE_STEP,  5'd0,  8'd0,   1'b1, 8'h00, 8'h00},
      '{mpss_pkg::MODE_WRITE, 5'd0,  8'd255, 1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_WRITE, 5'd31, 8'd1,   1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_WRITE, 5'd7,  8'd128, 1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_WRITE, 5'd8,  8'd254, 1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_WRITE, 5'd15, 8'd200, 1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_STEP,  5'd31, 8'd255, 1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_WRITE, 5'd16, 8'd50,  1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_STEP,  5'd0,  8'd0,   1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_STEP,  5'd0,  8'd0,   1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_STEP,  5'd0,  8'd0,   1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_STEP,  5'd0,  8'd0,   1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_STEP,  5'd0,  8'd0,   1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_WRITE, 5'd24, 8'd255, 1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_STEP,  5'd0,  8'd0,   1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_STEP,  5'd0,  8'd0,   1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_STEP,  5'd0,  8'd0,   1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_STEP,  5'd0,  8'd0,   1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_STEP,  5'd0,  8'd0,   1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_STEP,  5'd0,  8'd0,   1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_STEP,  5'd0,  8'd0,   1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_WRITE, 5'd5,  8'd0,   1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_WRITE, 5'd31, 8'd255, 1'b0, 8'h00, 8'h00},
      '{mpss_pkg::MODE_STEP,  5'd0,  8'd0,   1'b0, 8'h00, 8'h00}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Local copy of the scheduler state.
   logic [7:0]  duty_pending [mpss_pkg::CHANNELS];
   logic [7:0]  duty_live [mpss_pkg::CHANNELS];
   logic        duty_waiting;
   logic [7:0]  level_now;
   logic [5:0]  channels_cfg;

   mask_byte_type mask_bytes_due [$];
   int          mismatches = 0;
   int          rsp_hold_left = 0;
   bit          no_idle = 1'b0;

   multichannel_pwm_step_scheduler u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Number of channels that take part in a step for a register value.
   function automatic int live_channels(input logic [5:0] cfg);
      int n;
      n = int'(cfg);
      if (n < 1) n = 1;
      if (n > mpss_pkg::CAP) n = mpss_pkg::CAP;
      return n;
   endfunction

   // Applies one accepted item to the local state and queues its mask bytes.
   task automatic advance_scheduler(input logic mode, input logic [4:0] chan,
                                    input logic [7:0] duty, input bit emit);
      int            n;
      int            ch;
      logic [8:0]    least;
      logic          on;
      logic [7:0]    bits;
      mask_byte_type b;
      n = live_channels(channels_cfg);
      if (mode == mpss_pkg::MODE_WRITE) begin
         if (int'(chan) < n) begin
            duty_pending[chan] = duty;
            duty_waiting = 1'b1;
         end
         return;
      end
      // A new cycle picks up any waiting duty writes.
      if (level_now == 8'd0 && duty_waiting) begin
         duty_live = duty_pending;
         duty_waiting = 1'b0;
      end
      least = 9'd255;
      for (ch = 0; ch < n; ch++) begin
         if (duty_live[ch] > level_now && 9'(duty_live[ch]) < least)
            least = 9'(duty_live[ch]);
      end
      if (least == 9'd255) least = 9'd0;
      // Channels shift in from the top bit, eight per byte.
      bits = 8'd0;
      for (ch = 0; ch < n; ch++) begin
         on = (duty_live[ch] > level_now) || (level_now == mpss_pkg::LEVEL_MAX);
         bits = {on, bits[7:1]};
         if (ch % 8 == 7 || ch == n - 1) begin
            b.pattern = bits;
            b.last = (ch == n - 1);
            b.next_level = b.last ? least[7:0] : 8'd0;
            if (emit) mask_bytes_due.push_back(b);
            bits = 8'd0;
         end
      end
      level_now = least[7:0];
   endtask

   // Offers one item and waits for its transfer; the valid stays high after it.
   task automatic send_item(input logic mode, input logic [4:0] chan,
                            input logic [7:0] duty, input bit emit);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {3'b000, duty, chan};
      do @(posedge clock); while (!req_tready);
      advance_scheduler(mode, chan, duty, emit);
   endtask

   // Lowers the input valid and waits until every queued byte has arrived.
   task automatic wait_results;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (mask_bytes_due.size() != 0) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle.
   task automatic write_channels(input logic [5:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_ACTIVE_CHANNELS;
      csr_pwdata  <= {26'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      channels_cfg = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Random item, mostly within the live channels and with a share of
   // extreme duties. Returns whether the block does anything with it.
   task automatic random_item(output bit counted);
      logic       mode;
      logic [4:0] chan;
      logic [7:0] duty;
      int         n;
      n = live_channels(channels_cfg);
      mode = ($urandom_range(99) < 55) ? mpss_pkg::MODE_STEP : mpss_pkg::MODE_WRITE;
      chan = ($urandom_range(99) < 80) ? 5'($urandom_range(n - 1)) : 5'($urandom_range(31));
      if ($urandom_range(99) < 15) begin
         case ($urandom_range(3))
            0: duty = 8'd0;
            1: duty = 8'd1;
            2: duty = 8'd254;
            default: duty = 8'd255;
         endcase
      end else begin
         duty = 8'($urandom_range(255));
      end
      counted = (mode == mpss_pkg::MODE_STEP) || (int'(chan) < n);
      send_item(mode, chan, duty, 1'b1);
   endtask

   // Result side readiness, with a counted hold-off on request.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left = rsp_hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= 24);
         end
      end
   end

   // Compare each result transfer with the oldest expected byte.
   always @(posedge clock) begin
      mask_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mask_bytes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected byte pattern=%h next=%h last=%b",
                        $realtime, rsp_tdata[7:0], rsp_tdata[15:8], rsp_tlast);
         end else begin
            want = mask_bytes_due.pop_front();
            if (rsp_tdata[7:0] !== want.pattern || rsp_tdata[15:8] !== want.next_level ||
                rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: expected pattern=%h next=%h last=%b, got %h %h %b",
                           $realtime, want.pattern, want.next_level, want.last,
                           rsp_tdata[7:0], rsp_tdata[15:8], rsp_tlast);
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Stimulus.
   initial begin
      int            row;
      int            phase;
      int            done;
      int            k;
      int            n;
      bit            counted;
      mask_byte_type b;
      logic [5:0]    cfg;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= 16'd0;
      req_tuser   <= mpss_pkg::MODE_WRITE;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= 3'd0;
      csr_pwdata  <= 32'd0;
      for (k = 0; k < mpss_pkg::CHANNELS; k++) begin
         duty_pending[k] = 8'd0;
         duty_live[k] = 8'd0;
      end
      duty_waiting = 1'b0;
      level_now = 8'd0;
      channels_cfg = mpss_pkg::COUNT_RESET;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table at 32 channels, set by a register write.
      write_channels(6'd32);
      for (row = 0; row < NUM_ROWS; row++) begin
         send_item(ROWS[row].mode, ROWS[row].chan, ROWS[row].duty, !ROWS[row].typed);
         if (ROWS[row].typed) begin
            n = live_channels(channels_cfg);
            for (k = 0; k < (n + 7) / 8; k++) begin
               b.pattern = ROWS[row].exp_pattern;
               b.last = (k == (n + 7) / 8 - 1);
               b.next_level = b.last ? ROWS[row].exp_next : 8'd0;
               mask_bytes_due.push_back(b);
            end
         end
      end

      // Random phases, each under its own channel count.
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_results();
         repeat (DRAIN_CYCLES) @(posedge clock);
         case (phase)
            0: cfg = 6'd1;
            1: cfg = 6'd9;
            2: cfg = 6'd0;
            3: cfg = 6'd63;
            4: cfg = 6'd17;
            5: cfg = 6'd8;
            default: cfg = 6'($urandom_range(63));
         endcase
         write_channels(cfg);
         no_idle = (phase == 4);
         // Long result hold-off while the sender keeps offering.
         if (phase == 3) rsp_hold_left = 300;
         done = 0;
         while (done < PHASE_ITEMS) begin
            random_item(counted);
            if (counted) done++;
            // Sender pause until everything queued has come out.
            if (phase == 5 && done == PHASE_ITEMS / 2 && counted) wait_results();
         end
         no_idle = 1'b0;
      end

      // Drain and let the block settle.
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && mask_bytes_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
